// ===== hdl/fixed_to_decimal_text_assert.svh =====
// assertion macros used by the checker file
`ifndef FIXED_TO_DECIMAL_TEXT_ASSERT_SVH
`define FIXED_TO_DECIMAL_TEXT_ASSERT_SVH

// same-cycle implication
`define FDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fdt_pkg.sv =====
// shared types, constants and tables of the decimal text converter
package fdt_pkg;

   localparam int DEF_MAX_PLACES = 9;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int VALUE_W  = 32;
   localparam int PLACES_W = 4;
   localparam int CHAR_W   = 8;
   localparam int POW_W    = 30;
   localparam int PROD_W   = VALUE_W + POW_W;
   localparam int SUM_W    = 64;
   localparam int BIN_W    = 32;
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic             start;
      logic [BIN_W-1:0] bin;
   } cnv_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } cnv_res_type;

   function automatic logic [POW_W-1:0] pow_ten(input logic [PLACES_W-1:0] n);
      logic [POW_W-1:0] r;
      case (n)
         4'd0:    r = 30'd1;
         4'd1:    r = 30'd10;
         4'd2:    r = 30'd100;
         4'd3:    r = 30'd1000;
         4'd4:    r = 30'd10000;
         4'd5:    r = 30'd100000;
         4'd6:    r = 30'd1000000;
         4'd7:    r = 30'd10000000;
         4'd8:    r = 30'd100000000;
         4'd9:    r = 30'd1000000000;
         default: r = 30'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/fdt_if.sv =====
// valid/ready channel interfaces for numbers in and characters out
interface fdt_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fdt_pkg::VALUE_W-1:0]  value;
   logic        [fdt_pkg::PLACES_W-1:0] places;

   modport source (output valid, output value, output places, input ready);
   modport sink   (input valid, input value, input places, output ready);
endinterface

interface fdt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fdt_pkg::CHAR_W-1:0]  char_code;
   logic                        last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hdl/fdt_bin2bcd.sv =====
// iterative binary to bcd converter, one shift-and-adjust step per cycle
module fdt_bin2bcd (
   input  logic                  clock,
   input  logic                  reset,
   input  fdt_pkg::cnv_ctrl_type ctrl,
   output fdt_pkg::cnv_res_type  res
);

   localparam int CNT_W = $clog2(fdt_pkg::BIN_W);

   logic [fdt_pkg::BIN_W-1:0] bin_ff;
   logic [fdt_pkg::BCD_W-1:0] bcd_ff;
   logic [fdt_pkg::BCD_W-1:0] adj_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      last_step;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < fdt_pkg::DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj_in[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj_in[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign last_step = busy_ff && (cnt_ff == CNT_W'(fdt_pkg::BIN_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         bin_ff  <= ctrl.bin;
         bcd_ff  <= '0;
      end else if (busy_ff) begin
         bcd_ff  <= {adj_in[fdt_pkg::BCD_W-2:0], bin_ff[fdt_pkg::BIN_W-1]};
         bin_ff  <= {bin_ff[fdt_pkg::BIN_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign res.done = last_step;
   assign res.bcd  = bcd_ff;

endmodule

// ===== hdl/fixed_to_decimal_text.sv =====
// Fixed-point to decimal text converter. Each number on req_ch (signed, FRAC_BITS fraction bits)
// comes out on rsp_ch as ASCII characters: an optional '-', the digits of
// round_half_up(|value| * 10^places) saturated at 4294967295, zero padded to at least
// places+1 digits, with '.' before the last places digits; last_char marks the final
// character. places above min(MAX_PLACES, 9) is clamped to that bound. One number at a time:
// after acceptance req_ch.ready stays low through the multiply state, the rounding state, the
// shift-and-adjust bcd converter and the state that sizes the text, then while the characters
// (1 to 12) go out, one character per cycle while rsp_ch takes them, until rsp_ch has taken
// the last character.
module fixed_to_decimal_text #(
   parameter int MAX_PLACES = fdt_pkg::DEF_MAX_PLACES,
   parameter int FRAC_BITS  = fdt_pkg::DEF_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   fdt_req_if.sink  req_ch,
   fdt_rsp_if.source rsp_ch
);

   localparam int PLACES_CAP = (MAX_PLACES < 9) ? MAX_PLACES : 9;
   localparam logic [fdt_pkg::PLACES_W-1:0] CAP = fdt_pkg::PLACES_W'(PLACES_CAP);
   localparam logic [fdt_pkg::SUM_W-1:0] HALF =
      (FRAC_BITS > 0) ? (64'd1 << ((FRAC_BITS - 1) & 63)) : 64'd0;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_RND, S_CONV, S_FIND, S_EMIT, S_DRAIN
   } state_type;

   state_type                         state_ff;
   logic                              neg_ff;
   logic [fdt_pkg::VALUE_W-1:0]       mag_ff;
   logic [fdt_pkg::PLACES_W-1:0]      places_ff;
   logic [fdt_pkg::PROD_W-1:0]        prod_ff;
   logic [fdt_pkg::PLACES_W-1:0]      k_ff;
   logic                              dot_done_ff;
   logic                              rsp_valid_ff;
   logic [fdt_pkg::CHAR_W-1:0]        char_ff;
   logic                              last_ff;

   logic [fdt_pkg::PLACES_W-1:0]      places_in;
   logic [fdt_pkg::VALUE_W-1:0]       mag_in;
   logic [fdt_pkg::SUM_W-1:0]         sum;
   logic [fdt_pkg::SUM_W-1:0]         shifted;
   logic [fdt_pkg::BIN_W-1:0]         scaled;
   logic [fdt_pkg::PLACES_W-1:0]      ndig;
   logic [fdt_pkg::PLACES_W-1:0]      k_in;
   logic [fdt_pkg::PLACES_W-1:0]      k_idx;
   logic [3:0]                        dig;
   logic                              dot_due;
   logic                              out_free;

   fdt_pkg::cnv_ctrl_type             cnv_ctrl;
   fdt_pkg::cnv_res_type              cnv_res;

   assign places_in = (req_ch.places > CAP) ? CAP : req_ch.places;
   assign mag_in    = req_ch.value[fdt_pkg::VALUE_W-1] ?
                      fdt_pkg::VALUE_W'(-req_ch.value) : req_ch.value;

   // round half up, drop the fraction, clip to 32 bits
   assign sum     = fdt_pkg::SUM_W'(prod_ff) + HALF;
   assign shifted = sum >> FRAC_BITS;
   assign scaled  = (|shifted[fdt_pkg::SUM_W-1:fdt_pkg::BIN_W]) ? '1 :
                    shifted[fdt_pkg::BIN_W-1:0];

   assign cnv_ctrl.start = (state_ff == S_RND);
   assign cnv_ctrl.bin   = scaled;

   fdt_bin2bcd u_bin2bcd (
      .clock (clock),
      .reset (reset),
      .ctrl  (cnv_ctrl),
      .res   (cnv_res)
   );

   // digit count of the value, widened to places+1
   always_comb begin
      ndig = '0;
      for (int i = 0; i < fdt_pkg::DIGITS; i++) begin
         if (cnv_res.bcd[4*i +: 4] != 4'd0) begin
            ndig = fdt_pkg::PLACES_W'(i + 1);
         end
      end
      k_in = (ndig > places_ff) ? ndig : places_ff + 4'd1;
   end

   assign k_idx    = k_ff - 4'd1;
   assign dig      = cnv_res.bcd[{k_idx, 2'b00} +: 4];
   assign dot_due  = (places_ff != '0) && (k_ff == places_ff) && !dot_done_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  neg_ff    <= req_ch.value[fdt_pkg::VALUE_W-1];
                  mag_ff    <= mag_in;
                  places_ff <= places_in;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= mag_ff * fdt_pkg::pow_ten(places_ff);
               state_ff <= S_RND;
            end
            S_RND: begin
               state_ff <= S_CONV;
            end
            S_CONV: begin
               if (cnv_res.done) begin
                  state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               k_ff        <= k_in;
               dot_done_ff <= 1'b0;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (neg_ff) begin
                     char_ff <= fdt_pkg::CHAR_MINUS;
                     last_ff <= 1'b0;
                     neg_ff  <= 1'b0;
                  end else if (dot_due) begin
                     char_ff     <= fdt_pkg::CHAR_POINT;
                     last_ff     <= 1'b0;
                     dot_done_ff <= 1'b1;
                  end else begin
                     char_ff     <= fdt_pkg::CHAR_ZERO + {4'd0, dig};
                     last_ff     <= (k_ff == 4'd1);
                     k_ff        <= k_idx;
                     dot_done_ff <= 1'b0;
                     if (k_ff == 4'd1) begin
                        state_ff <= S_DRAIN;
                     end
                  end
               end
            end
            S_DRAIN: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_code = char_ff;
   assign rsp_ch.last_char = last_ff;

endmodule

// ===== hdl/fdt_checker.sv =====
// port-level checks of the decimal text converter, bound to the top level
`include "fixed_to_decimal_text_assert.svh"

module fdt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fdt_pkg::CHAR_W-1:0] rsp_char_code,
   input logic                       rsp_last_char
);

   `FDT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_code) && $stable(rsp_last_char), "stalled character changed")
   `FDT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "took a second item while busy")
   `FDT_ASSERT_NXT(a_idle_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last_char, !rsp_valid && req_ready, "not idle after final character")
   `FDT_ASSERT_IMP(a_quiet_when_ready, clock, reset, req_ready, !rsp_valid, "character shown while idle")

endmodule

bind fixed_to_decimal_text fdt_checker u_fdt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_last_char (rsp_ch.last_char)
);
